/* rtl/rwrc_pkg.sv */
`default_nettype none

package rwrc_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int RATE_W          = 17;
  localparam int CHCNT_W         = 2;
  localparam int CNT_W           = 32;
  localparam int SUM_W           = 48;
  localparam int RMS_W           = 16;
  localparam int DEN_W           = RATE_W + 1;
  localparam int DIV_W           = RATE_W + CNT_W + 2;
  localparam int ROOT_W          = SUM_W / 2;
  localparam int STEP_W          = $clog2(DIV_W + 1);
  localparam int CFG_IDX_W       = 2;

  localparam logic [RATE_W-1:0]  AUDIO_RATE_RST    = RATE_W'(44100);
  localparam logic [RATE_W-1:0]  ADC_RATE_RST      = RATE_W'(256);
  localparam logic [CHCNT_W-1:0] CHANNEL_COUNT_RST = CHCNT_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AUDIO_RATE    = 2'd0,
    CFG_ADC_RATE      = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DIV_QR,
    DIV_BN,
    DIV_MEAN
  } div_op_t;

  typedef struct packed {
    logic    take_in;
    logic    clear_run;
    logic    accum;
    logic    div_start;
    div_op_t div_op;
    logic    cap_qr;
    logic    cap_bn;
    logic    cap_mean;
    logic    sqrt_start;
    logic    cap_root;
    logic    ch_sel;
    logic    load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic sqrt_done;
    logic close;
    logic stereo;
  } sts_t;

endpackage

`default_nettype wire

/* rtl/rms_window_rate_converter.sv */
// Channel   Handshake                 Payload
// in        in_valid / in_ready       in_action, in_sample_ch0, in_sample_ch1
// out       out_valid / out_ready     out_rms_ch0, out_rms_ch1, out_window_length,
//                                     out_window_index
// cfg       cfg_valid / cfg_ready     cfg_index, cfg_data
//
// After an audio frame is accepted, ready stays low through the two serial divisions for the
// window boundary (18 and 51 quotient bits, one per cycle).
// A start transaction is taken without leaving the idle state. A frame that closes a window adds
// a mean division and a square root per channel in use, plus a step to load the result.
// Reset is synchronous and active low; it restores the register defaults and clears the run.
// A result waits in the output register while the next frame is processed; a closing frame
// stalls until that register is free.
`default_nettype none

module rms_window_rate_converter import rwrc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_action,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_ch0,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_ch1,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [RMS_W-1:0]              out_rms_ch0,
  output logic [RMS_W-1:0]              out_rms_ch1,
  output logic [RATE_W-1:0]             out_window_length,
  output logic [CNT_W-1:0]              out_window_index,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [RATE_W-1:0]             cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  rwrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rwrc_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_sample_ch0     (in_sample_ch0),
    .in_sample_ch1     (in_sample_ch1),
    .cmd               (cmd),
    .sts               (sts),
    .out_rms_ch0       (out_rms_ch0),
    .out_rms_ch1       (out_rms_ch1),
    .out_window_length (out_window_length),
    .out_window_index  (out_window_index)
  );

endmodule

`default_nettype wire

/* rtl/rwrc_div.sv */
`default_nettype none

module rwrc_div import rwrc_pkg::*; #(
  parameter int NUM_W = DIV_W,
  parameter int DN_W  = DEN_W,
  parameter int ST_W  = $clog2(NUM_W + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DN_W-1:0]  den,
  input  logic [ST_W-1:0]  steps,
  output logic [NUM_W-1:0] quo,
  output logic [DN_W-1:0]  rem,
  output logic             done
);

  logic [NUM_W-1:0] quo_r;
  logic [DN_W-1:0]  rem_r;
  logic [DN_W-1:0]  den_r;
  logic [ST_W-1:0]  cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [DN_W:0]    rem_sh;
  logic             ge;
  logic [DN_W:0]    rem_sub;

  assign rem_sh  = {rem_r, quo_r[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_sub = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - ST_W'(1);
        if (cnt_r == ST_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NUM_W-2:0], ge};
      rem_r <= ge ? rem_sub[DN_W-1:0] : rem_sh[DN_W-1:0];
    end
  end

  assign quo  = quo_r;
  assign rem  = rem_r;
  assign done = done_r;

endmodule

`default_nettype wire

/* rtl/rwrc_sqrt.sv */
`default_nettype none

module rwrc_sqrt import rwrc_pkg::*; #(
  parameter int IN_W = SUM_W,
  parameter int RT_W = IN_W / 2,
  parameter int ST_W = $clog2(RT_W + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [IN_W-1:0] val,
  output logic [RT_W-1:0] root,
  output logic            done
);

  logic [IN_W-1:0] val_r;
  logic [RT_W+1:0] rem_r;
  logic [RT_W-1:0] root_r;
  logic [ST_W-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [RT_W+3:0] rem_sh;
  logic [RT_W+3:0] trial;
  logic            ge;
  logic [RT_W+3:0] rem_sub;

  assign rem_sh  = {rem_r, val_r[IN_W-1:IN_W-2]};
  assign trial   = (RT_W + 4)'({root_r, 2'b01});
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= ST_W'(RT_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - ST_W'(1);
        if (cnt_r == ST_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_r  <= val;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      val_r  <= val_r << 2;
      rem_r  <= ge ? rem_sub[RT_W+1:0] : rem_sh[RT_W+1:0];
      root_r <= {root_r[RT_W-2:0], ge};
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

`default_nettype wire

/* rtl/rwrc_dp.sv */
`default_nettype none

module rwrc_dp import rwrc_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [RATE_W-1:0]             cfg_data,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_ch0,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_ch1,
  input  cmd_t                          cmd,
  output sts_t                          sts,
  output logic [RMS_W-1:0]              out_rms_ch0,
  output logic [RMS_W-1:0]              out_rms_ch1,
  output logic [RATE_W-1:0]             out_window_length,
  output logic [CNT_W-1:0]              out_window_index
);

  localparam int PROD_W = DEN_W + CNT_W;

  logic [RATE_W-1:0]             audio_rate_r;
  logic [RATE_W-1:0]             adc_rate_r;
  logic [CHCNT_W-1:0]            chcnt_r;
  logic [RATE_W-1:0]             a_eff;
  logic [RATE_W-1:0]             d_raw;
  logic [RATE_W-1:0]             d_eff;
  logic [DEN_W-1:0]              a2;
  logic [DEN_W-1:0]              d2;
  logic                          stereo;

  logic signed [SAMPLE_BITS-1:0] smp0_r;
  logic signed [SAMPLE_BITS-1:0] smp1_r;
  logic signed [2*SAMPLE_BITS-1:0] sq0;
  logic signed [2*SAMPLE_BITS-1:0] sq1;
  logic [SUM_W:0]                add0;
  logic [SUM_W:0]                add1;
  logic [SUM_W-1:0]              sum0_r;
  logic [SUM_W-1:0]              sum1_r;
  logic [RATE_W-1:0]             fill_r;
  logic [CNT_W-1:0]              n_r;
  logic [PROD_W-1:0]             prod_nxt;
  logic [PROD_W-1:0]             prod_r;

  logic [RATE_W-1:0]             qa_r;
  logic [DEN_W-1:0]              ra_r;
  logic [DEN_W-1:0]              r0_r;
  logic [DEN_W:0]                rsum;
  logic [DEN_W-1:0]              win_len;
  logic [SUM_W-1:0]              mean_r;
  logic [ROOT_W-1:0]             root0_r;
  logic [ROOT_W-1:0]             root1_r;

  logic [DIV_W-1:0]              div_num;
  logic [DEN_W-1:0]              div_den;
  logic [STEP_W-1:0]             div_steps;
  logic [DIV_W-1:0]              div_quo;
  logic [DEN_W-1:0]              div_rem;
  logic                          div_done;
  logic [ROOT_W-1:0]             sqrt_root;
  logic                          sqrt_done;

  logic [RMS_W-1:0]              rms0_r;
  logic [RMS_W-1:0]              rms1_r;
  logic [RATE_W-1:0]             len_out_r;
  logic [CNT_W-1:0]              idx_out_r;

  // A zero rate acts as one, and the window rate is clamped to the audio rate.
  assign a_eff  = (audio_rate_r == '0) ? RATE_W'(1) : audio_rate_r;
  assign d_raw  = (adc_rate_r == '0) ? RATE_W'(1) : adc_rate_r;
  assign d_eff  = (d_raw > a_eff) ? a_eff : d_raw;
  assign a2     = {a_eff, 1'b0};
  assign d2     = {d_eff, 1'b0};
  assign stereo = chcnt_r[1];

  assign sq0      = smp0_r * smp0_r;
  assign sq1      = smp1_r * smp1_r;
  assign add0     = {1'b0, sum0_r} + (SUM_W + 1)'($unsigned(sq0));
  assign add1     = {1'b0, sum1_r} + (SUM_W + 1)'($unsigned(sq1));
  assign prod_nxt = a2 * n_r;

  // With 2a = Q*2d + R and B(n) = q0 rem r0, the window length is Q plus
  // one more when r0 + R reaches 2d.
  assign rsum    = {1'b0, r0_r} + {1'b0, ra_r};
  assign win_len = DEN_W'(qa_r) + DEN_W'(rsum >= {1'b0, d2});

  always_comb begin
    unique case (cmd.div_op)
      DIV_QR: begin
        div_num   = DIV_W'(a2) << (DIV_W - DEN_W);
        div_den   = d2;
        div_steps = STEP_W'(DEN_W);
      end
      DIV_BN: begin
        div_num   = DIV_W'(prod_r) + DIV_W'(d_eff);
        div_den   = d2;
        div_steps = STEP_W'(DIV_W);
      end
      DIV_MEAN: begin
        div_num   = DIV_W'(cmd.ch_sel ? sum1_r : sum0_r);
        div_den   = DEN_W'(fill_r);
        div_steps = STEP_W'(DIV_W);
      end
      default: begin
        div_num   = '0;
        div_den   = d2;
        div_steps = STEP_W'(DIV_W);
      end
    endcase
  end

  rwrc_div #(
    .NUM_W (DIV_W),
    .DN_W  (DEN_W),
    .ST_W  (STEP_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .steps (div_steps),
    .quo   (div_quo),
    .rem   (div_rem),
    .done  (div_done)
  );

  rwrc_sqrt #(
    .IN_W (SUM_W),
    .RT_W (ROOT_W)
  ) u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sqrt_start),
    .val   (mean_r),
    .root  (sqrt_root),
    .done  (sqrt_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      audio_rate_r <= AUDIO_RATE_RST;
      adc_rate_r   <= ADC_RATE_RST;
      chcnt_r      <= CHANNEL_COUNT_RST;
      n_r          <= '0;
      fill_r       <= '0;
      sum0_r       <= '0;
      sum1_r       <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_idx_t'(cfg_index))
          CFG_AUDIO_RATE:    audio_rate_r <= cfg_data;
          CFG_ADC_RATE:      adc_rate_r   <= cfg_data;
          CFG_CHANNEL_COUNT: chcnt_r      <= cfg_data[CHCNT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clear_run || cmd.load_out) begin
        fill_r <= '0;
        sum0_r <= '0;
        sum1_r <= '0;
        n_r    <= cmd.clear_run ? '0 : n_r + CNT_W'(1);
      end else if (cmd.accum) begin
        fill_r <= fill_r + RATE_W'(1);
        sum0_r <= add0[SUM_W] ? '1 : add0[SUM_W-1:0];
        if (stereo) begin
          sum1_r <= add1[SUM_W] ? '1 : add1[SUM_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_in) begin
      smp0_r <= in_sample_ch0;
      smp1_r <= in_sample_ch1;
    end
    if (cmd.accum) begin
      prod_r <= prod_nxt;
    end
    if (cmd.cap_qr) begin
      qa_r <= div_quo[RATE_W-1:0];
      ra_r <= div_rem;
    end
    if (cmd.cap_bn) begin
      r0_r <= div_rem;
    end
    if (cmd.cap_mean) begin
      mean_r <= div_quo[SUM_W-1:0];
    end
    if (cmd.cap_root) begin
      if (cmd.ch_sel) begin
        root1_r <= sqrt_root;
      end else begin
        root0_r <= sqrt_root;
      end
    end
    if (cmd.load_out) begin
      rms0_r    <= root0_r[RMS_W-1:0];
      rms1_r    <= stereo ? root1_r[RMS_W-1:0] : '0;
      len_out_r <= fill_r;
      idx_out_r <= n_r;
    end
  end

  assign sts.div_done  = div_done;
  assign sts.sqrt_done = sqrt_done;
  assign sts.close     = DEN_W'(fill_r) >= win_len;
  assign sts.stereo    = stereo;

  assign out_rms_ch0       = rms0_r;
  assign out_rms_ch1       = rms1_r;
  assign out_window_length = len_out_r;
  assign out_window_index  = idx_out_r;

endmodule

`default_nettype wire

/* rtl/rwrc_ctrl.sv */
`default_nettype none

module rwrc_ctrl import rwrc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_action,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_QR_GO,
    S_QR_WAIT,
    S_BN_GO,
    S_BN_WAIT,
    S_CHK,
    S_MEAN_GO,
    S_MEAN_WAIT,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_EMIT
  } state_t;

  state_t state_r;
  logic   ch_r;
  logic   out_valid_r;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd        = '0;
    cmd.ch_sel = ch_r;
    cmd.div_op = DIV_QR;
    unique case (state_r)
      S_IDLE: begin
        cmd.take_in   = in_valid;
        cmd.clear_run = in_valid && in_action;
      end
      S_ACC:       cmd.accum = 1'b1;
      S_QR_GO:     cmd.div_start = 1'b1;
      S_QR_WAIT:   cmd.cap_qr = sts.div_done;
      S_BN_GO: begin
        cmd.div_op    = DIV_BN;
        cmd.div_start = 1'b1;
      end
      S_BN_WAIT: begin
        cmd.div_op = DIV_BN;
        cmd.cap_bn = sts.div_done;
      end
      S_CHK: ;
      S_MEAN_GO: begin
        cmd.div_op    = DIV_MEAN;
        cmd.div_start = 1'b1;
      end
      S_MEAN_WAIT: begin
        cmd.div_op   = DIV_MEAN;
        cmd.cap_mean = sts.div_done;
      end
      S_ROOT_GO:   cmd.sqrt_start = 1'b1;
      S_ROOT_WAIT: cmd.cap_root = sts.sqrt_done;
      S_EMIT:      cmd.load_out = slot_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_EMIT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && !in_action) begin
            state_r <= S_ACC;
          end
        end
        S_ACC:     state_r <= S_QR_GO;
        S_QR_GO:   state_r <= S_QR_WAIT;
        S_QR_WAIT: begin
          if (sts.div_done) begin
            state_r <= S_BN_GO;
          end
        end
        S_BN_GO:   state_r <= S_BN_WAIT;
        S_BN_WAIT: begin
          if (sts.div_done) begin
            state_r <= S_CHK;
          end
        end
        S_CHK: begin
          ch_r    <= 1'b0;
          state_r <= sts.close ? S_MEAN_GO : S_IDLE;
        end
        S_MEAN_GO:   state_r <= S_MEAN_WAIT;
        S_MEAN_WAIT: begin
          if (sts.div_done) begin
            state_r <= S_ROOT_GO;
          end
        end
        S_ROOT_GO:   state_r <= S_ROOT_WAIT;
        S_ROOT_WAIT: begin
          if (sts.sqrt_done) begin
            if (!ch_r && sts.stereo) begin
              ch_r    <= 1'b1;
              state_r <= S_MEAN_GO;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* bench/rwrc_checker.sv */
`timescale 1ns / 1ps

module rwrc_checker import rwrc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_action,
  input  logic signed [15:0]   in_sample_ch0,
  input  logic signed [15:0]   in_sample_ch1,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [RMS_W-1:0]     out_rms_ch0,
  input  logic [RMS_W-1:0]     out_rms_ch1,
  input  logic [RATE_W-1:0]    out_window_length,
  input  logic [CNT_W-1:0]     out_window_index,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RATE_W-1:0]    cfg_data,
  output int                   fail_count,
  output int                   pending
);

  localparam logic [63:0] SUM_CEIL   = 64'hFFFF_FFFF_FFFF;
  localparam int          REPORT_MAX = 10;

  typedef struct packed {
    logic [RMS_W-1:0]  rms_ch0;
    logic [RMS_W-1:0]  rms_ch1;
    logic [RATE_W-1:0] window_length;
    logic [CNT_W-1:0]  window_index;
  } window_rms_t;

  window_rms_t        awaited_windows[$];
  logic [RATE_W-1:0]  audio_rate_r;
  logic [RATE_W-1:0]  adc_rate_r;
  logic [CHCNT_W-1:0] channel_count_r;
  logic [CNT_W-1:0]   windows_closed;
  logic [63:0]        frames_in_window;
  logic [63:0]        energy [2];
  int                 mismatches;

  function automatic logic [63:0] window_edge(input logic [63:0] n);
    logic [63:0] a;
    logic [63:0] d;
    a = (audio_rate_r == '0) ? 64'd1 : 64'(audio_rate_r);
    d = (adc_rate_r == '0) ? 64'd1 : 64'(adc_rate_r);
    if (d > a) begin
      d = a;
    end
    return (64'd2 * a * n + d) / (64'd2 * d);
  endfunction

  function automatic logic [RMS_W-1:0] int_root(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] b;
    rem = v;
    res = '0;
    b = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= res + b) begin
        rem = rem - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res[RMS_W-1:0];
  endfunction

  function automatic logic [63:0] add_square(input logic [63:0] acc,
                                             input logic signed [15:0] s);
    longint      sq;
    logic [63:0] total;
    sq = longint'(s) * longint'(s);
    total = acc + 64'(sq);
    return (total > SUM_CEIL) ? SUM_CEIL : total;
  endfunction

  task automatic clear_window_run();
    windows_closed = '0;
    frames_in_window = '0;
    energy[0] = '0;
    energy[1] = '0;
  endtask

  always @(posedge clk) begin : watch
    window_rms_t got;
    window_rms_t want;
    logic        stereo;
    logic [63:0] span;
    if (!rst_n) begin
      audio_rate_r = AUDIO_RATE_RST;
      adc_rate_r = ADC_RATE_RST;
      channel_count_r = CHANNEL_COUNT_RST;
      clear_window_run();
      awaited_windows.delete();
      mismatches = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.rms_ch0 = out_rms_ch0;
        got.rms_ch1 = out_rms_ch1;
        got.window_length = out_window_length;
        got.window_index = out_window_index;
        if (awaited_windows.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("checker: unexpected result rms %0d/%0d length %0d index %0d",
                     got.rms_ch0, got.rms_ch1, got.window_length, got.window_index);
          end
        end else begin
          want = awaited_windows.pop_front();
          if (got.rms_ch0 !== want.rms_ch0 || got.rms_ch1 !== want.rms_ch1 ||
              got.window_length !== want.window_length ||
              got.window_index !== want.window_index) begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("checker: window %0d expected rms %0d/%0d length %0d index %0d",
                       want.window_index, want.rms_ch0, want.rms_ch1,
                       want.window_length, want.window_index);
              $display("checker: window %0d actual   rms %0d/%0d length %0d index %0d",
                       want.window_index, got.rms_ch0, got.rms_ch1,
                       got.window_length, got.window_index);
            end
          end
        end
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_AUDIO_RATE: begin
            audio_rate_r = cfg_data;
          end
          CFG_ADC_RATE: begin
            adc_rate_r = cfg_data;
          end
          CFG_CHANNEL_COUNT: begin
            channel_count_r = cfg_data[CHCNT_W-1:0];
          end
          default: begin
          end
        endcase
      end

      if (in_valid && in_ready) begin
        if (in_action) begin
          clear_window_run();
        end else begin
          stereo = (channel_count_r >= 2);
          energy[0] = add_square(energy[0], in_sample_ch0);
          if (stereo) begin
            energy[1] = add_square(energy[1], in_sample_ch1);
          end
          frames_in_window++;
          span = window_edge(64'(windows_closed) + 64'd1) - window_edge(64'(windows_closed));
          if (frames_in_window >= span) begin
            want.rms_ch0 = int_root(energy[0] / frames_in_window);
            want.rms_ch1 = stereo ? int_root(energy[1] / frames_in_window) : '0;
            want.window_length = frames_in_window[RATE_W-1:0];
            want.window_index = windows_closed;
            awaited_windows.push_back(want);
            windows_closed++;
            frames_in_window = '0;
            energy[0] = '0;
            energy[1] = '0;
          end
        end
      end
    end
    pending <= awaited_windows.size();
    fail_count <= mismatches;
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
  import rwrc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 400;
  localparam int IDLE_PCT      = 22;
  localparam int START_PCT     = 3;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 96;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_action = 1'b0;
  logic signed [15:0]   in_sample_ch0 = '0;
  logic signed [15:0]   in_sample_ch1 = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [RMS_W-1:0]     out_rms_ch0;
  logic [RMS_W-1:0]     out_rms_ch1;
  logic [RATE_W-1:0]    out_window_length;
  logic [CNT_W-1:0]     out_window_index;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RATE_W-1:0]    cfg_data = '0;
  logic                 steady = 1'b0;
  int                   fail_count;
  int                   pending;

  rms_window_rate_converter dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_sample_ch0     (in_sample_ch0),
    .in_sample_ch1     (in_sample_ch1),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_rms_ch0       (out_rms_ch0),
    .out_rms_ch1       (out_rms_ch1),
    .out_window_length (out_window_length),
    .out_window_index  (out_window_index),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  rwrc_checker u_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("tb: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(19))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic act, input logic [15:0] s0, input logic [15:0] s1);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_sample_ch0 <= s0;
    in_sample_ch1 <= s1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input int unsigned a, input int unsigned d, input int unsigned ch);
    settle();
    write_reg(CFG_AUDIO_RATE, RATE_W'(a));
    write_reg(CFG_ADC_RATE, RATE_W'(d));
    write_reg(CFG_CHANNEL_COUNT, RATE_W'(ch));
  endtask

  task automatic random_burst(input int count);
    for (int k = 0; k < count; k++) begin
      send_item($urandom_range(99) < START_PCT, pick_sample(), pick_sample());
    end
  endtask

  initial begin
    int unsigned rate_a;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    send_item(1'b0, 16'd8000, 16'd8001);
    send_item(1'b0, 16'h8000, 16'h7fff);
    send_item(1'b1, 16'h0000, 16'h0000);

    apply_config(1, 96000, 2);
    send_item(1'b0, 16'h8000, 16'h8000);
    send_item(1'b0, 16'h7fff, 16'h7fff);
    send_item(1'b0, 16'h0000, 16'h0000);
    send_item(1'b0, 16'hffff, 16'h0001);
    send_item(1'b0, 16'h7fff, 16'h8000);

    apply_config(1, 96000, 1);
    send_item(1'b0, 16'h8000, 16'h1234);
    apply_config(1, 96000, 0);
    send_item(1'b0, 16'h7fff, 16'h7fff);
    apply_config(1, 96000, 3);
    send_item(1'b0, 16'h0003, 16'hfffd);
    apply_config(0, 0, 2);
    send_item(1'b0, 16'h0100, 16'h0200);

    // Raising the window rate while a long window is open makes the next frame close it.
    apply_config(131071, 1, 2);
    send_item(1'b0, 16'h8000, 16'h7fff);
    send_item(1'b0, 16'h4000, 16'hc000);
    send_item(1'b0, 16'h0001, 16'hffff);
    send_item(1'b0, 16'h7fff, 16'h0000);
    settle();
    write_reg(CFG_ADC_RATE, RATE_W'(131071));
    send_item(1'b0, 16'h1111, 16'heeee);

    apply_config(96000, 1, 2);
    send_item(1'b0, 16'h8000, 16'h8000);
    send_item(1'b0, 16'h7fff, 16'h7fff);
    send_item(1'b1, 16'hffff, 16'hffff);
    settle();
    write_reg(CFG_ADC_RATE, RATE_W'(96000));
    write_reg(CFG_SPARE, RATE_W'(5));
    send_item(1'b0, 16'h0a0a, 16'hf5f5);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: apply_config(7, 3, 2);
        1: apply_config(5, 5, 1);
        2: apply_config(10, 3, 2);
        3: apply_config(96000, 48000, 2);
        4: apply_config(44100, 4410, 3);
        5: apply_config(3, 1, 0);
        6: apply_config(96000, 32000, 2);
        7: apply_config(50, 7, 2);
        default: begin
          rate_a = $urandom_range(400, 1);
          apply_config(rate_a, $urandom_range(rate_a + 20, (rate_a >= 16) ? rate_a / 16 : 1),
                       $urandom_range(3));
        end
      endcase
      steady <= (p == 6);
      random_burst(PHASE_ITEMS);
    end

    settle();
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

/* rms_window_rate_converter.f */
rtl/rwrc_pkg.sv
rtl/rwrc_div.sv
rtl/rwrc_sqrt.sv
rtl/rwrc_dp.sv
rtl/rwrc_ctrl.sv
rtl/rms_window_rate_converter.sv
bench/rwrc_checker.sv
bench/tb.sv
